>>> hw/rtl/mexp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the modular exponentiation block.
// Used by every module under hw/rtl; depends on nothing else.
package mexp_pkg;

  // Width of the payload fields and of the modulus register.
  localparam int FIELD_W = 16;

  // Default working width of operands and of the exponent scan.
  localparam int OPERAND_BITS_DEF = 16;

  // Configuration bus geometry.
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [DATA_W-1:0]  data_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [ADDR_W-3:0]  reg_idx_t;

  // Register index of the modulus.
  localparam reg_idx_t REG_MODULUS = '0;

  // Modulus value after reset.
  localparam field_t MODULUS_RESET = 16'd221;

  // Which product the shared multiplier is forming.
  typedef enum logic [1:0] {
    MSEL_REDUCE = 2'd0,
    MSEL_ACC    = 2'd1,
    MSEL_SQR    = 2'd2
  } mul_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     shift;
    logic     out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic m_zero;
    logic exp_bit;
    logic mul_done;
    logic out_free;
  } dp_status_t;

endpackage

>>> hw/rtl/mexp_modmul.sv
`timescale 1ns / 1ps
// Interleaved modular multiplier: x * y mod m, one bit of y per cycle, MSB first.
// Requires x < m. Takes its default width from mexp_pkg; instantiated by mexp_datapath.
module mexp_modmul #(
  parameter int OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [OPERAND_BITS-1:0] x,
  input  logic [OPERAND_BITS-1:0] y,
  input  logic [OPERAND_BITS-1:0] m,
  output logic                    done,
  output logic [OPERAND_BITS-1:0] result
);

  localparam int W     = OPERAND_BITS;
  localparam int CNT_W = $clog2(OPERAND_BITS);
  localparam int T_W   = OPERAND_BITS + 2;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [W-1:0]     x_r;
  logic [W-1:0]     y_r;
  logic [W-1:0]     r_r;
  logic [W-1:0]     r_nxt;
  logic [T_W-1:0]   t;
  logic [T_W-1:0]   m1;
  logic [T_W-1:0]   m2;
  logic [T_W-1:0]   d1;
  logic [T_W-1:0]   d2;

  // One step: r = 2r + y_bit * x, which stays below 3m, then subtract m or 2m.
  always_comb begin
    m1 = {2'b00, m};
    m2 = {1'b0, m, 1'b0};
    t  = {1'b0, r_r, 1'b0} + (y_r[W-1] ? {2'b00, x_r} : '0);
    d1 = t - m1;
    d2 = t - m2;
    priority if (t >= m2) begin
      r_nxt = d2[W-1:0];
    end else if (t >= m1) begin
      r_nxt = d1[W-1:0];
    end else begin
      r_nxt = t[W-1:0];
    end
  end

  // Control: busy while the bit counter runs down, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operand and partial-remainder registers.
  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x;
      y_r <= y;
      r_r <= '0;
    end else if (busy_r) begin
      r_r <= r_nxt;
      y_r <= y_r << 1;
    end
  end

  assign done   = done_r;
  assign result = r_r;

endmodule

>>> hw/rtl/mexp_datapath.sv
`timescale 1ns / 1ps
// Datapath of the modular exponentiation block: operand, accumulator and square
// registers, the shared modular multiplier and the result register. Uses mexp_pkg.
module mexp_datapath #(
  parameter int OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mexp_pkg::ctrl_cmd_t    cmd,
  output mexp_pkg::dp_status_t   status,
  input  mexp_pkg::field_t       modulus,
  input  mexp_pkg::field_t       in_base,
  input  mexp_pkg::field_t       in_exponent,
  output logic                   out_valid,
  input  logic                   out_stall,
  output mexp_pkg::field_t       out_power_residue
);

  localparam int W = OPERAND_BITS;

  logic [W-1:0]       base_r;
  logic [W-1:0]       exp_r;
  logic [W-1:0]       m_r;
  logic [W-1:0]       acc_r;
  logic [W-1:0]       sq_r;
  mexp_pkg::mul_sel_t sel_r;
  mexp_pkg::field_t   out_data_r;
  logic               out_valid_r;

  logic [W-1:0]       m_in;
  logic [W-1:0]       one_in;
  logic [W-1:0]       one_mod;
  logic [W-1:0]       mul_x;
  logic [W-1:0]       mul_y;
  logic               mul_done;
  logic [W-1:0]       mul_result;

  // Operands are taken in their low W bits; 1 mod m is 0 when m is 0 or 1.
  assign m_in    = W'(modulus);
  assign one_in  = {{(W-1){1'b0}}, (m_in > W'(1))};
  assign one_mod = {{(W-1){1'b0}}, (m_r > W'(1))};

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (cmd.mul_sel)
      mexp_pkg::MSEL_REDUCE: begin
        mul_x = one_mod;
        mul_y = base_r;
      end
      mexp_pkg::MSEL_ACC: begin
        mul_x = sq_r;
        mul_y = acc_r;
      end
      mexp_pkg::MSEL_SQR: begin
        mul_x = sq_r;
        mul_y = sq_r;
      end
      default: begin
        mul_x = sq_r;
        mul_y = sq_r;
      end
    endcase
  end

  mexp_modmul #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .m     (m_r),
    .done  (mul_done),
    .result(mul_result)
  );

  // Working registers: loaded with a request, updated as products complete.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r <= W'(in_base);
      exp_r  <= W'(in_exponent);
      m_r    <= m_in;
      acc_r  <= one_in;
    end else begin
      if (cmd.shift) begin
        exp_r <= exp_r >> 1;
      end
      if (mul_done) begin
        unique case (sel_r)
          mexp_pkg::MSEL_REDUCE: sq_r  <= mul_result;
          mexp_pkg::MSEL_ACC:    acc_r <= mul_result;
          mexp_pkg::MSEL_SQR:    sq_r  <= mul_result;
          default:               sq_r  <= mul_result;
        endcase
      end
    end
    if (cmd.mul_start) begin
      sel_r <= cmd.mul_sel;
    end
    if (cmd.out_load) begin
      out_data_r <= mexp_pkg::field_t'(acc_r);
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.m_zero   = (m_r == '0);
  assign status.exp_bit  = exp_r[0];
  assign status.mul_done = mul_done;
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_power_residue = out_data_r;

endmodule

>>> hw/rtl/mexp_ctrl.sv
`timescale 1ns / 1ps
// Controller of the modular exponentiation block: sequences the base reduction and
// the square-and-multiply passes over the exponent bits. Uses mexp_pkg.
module mexp_ctrl #(
  parameter int OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mexp_pkg::dp_status_t status,
  output mexp_pkg::ctrl_cmd_t  cmd
);

  localparam int CNT_W = $clog2(OPERAND_BITS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_RED  = 3'd2;
  localparam logic [2:0] S_BIT  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_SQR  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]       state_r;
  logic [2:0]       state_nxt;
  logic [CNT_W-1:0] bit_cnt_r;
  logic [CNT_W-1:0] bit_cnt_nxt;
  logic             last_bit;

  assign last_bit = (bit_cnt_r == CNT_W'(OPERAND_BITS - 1));

  // Next state and command decode.
  always_comb begin
    state_nxt   = state_r;
    bit_cnt_nxt = bit_cnt_r;
    cmd         = '0;
    cmd.mul_sel = mexp_pkg::MSEL_SQR;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          bit_cnt_nxt = '0;
          state_nxt   = S_LOAD;
        end
      end
      S_LOAD: begin
        if (status.m_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = mexp_pkg::MSEL_REDUCE;
          state_nxt     = S_RED;
        end
      end
      S_RED: begin
        if (status.mul_done) begin
          state_nxt = S_BIT;
        end
      end
      S_BIT: begin
        priority if (status.exp_bit) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = mexp_pkg::MSEL_ACC;
          state_nxt     = S_MUL;
        end else if (last_bit) begin
          state_nxt = S_DONE;
        end else begin
          cmd.mul_start = 1'b1;
          state_nxt     = S_SQR;
        end
      end
      S_MUL: begin
        if (status.mul_done) begin
          if (last_bit) begin
            state_nxt = S_DONE;
          end else begin
            cmd.mul_start = 1'b1;
            state_nxt     = S_SQR;
          end
        end
      end
      S_SQR: begin
        if (status.mul_done) begin
          cmd.shift   = 1'b1;
          bit_cnt_nxt = bit_cnt_r + 1'b1;
          state_nxt   = S_BIT;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and bit counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      bit_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      bit_cnt_r <= bit_cnt_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

>>> hw/rtl/modular_exponentiation_top.sv
`timescale 1ns / 1ps
// Top level of the modular exponentiation block: configuration port, controller and
// datapath. Uses mexp_pkg, mexp_ctrl, mexp_datapath and mexp_modmul.
//
// Computes in_base ** in_exponent mod modulus by right-to-left square-and-multiply,
// one request at a time. Operands are taken in their low OPERAND_BITS bits. Every
// product runs through one shared interleaved modular multiplier that retires one
// multiplier bit per cycle, and that unit sets the rate. A modulus of zero yields 0.
// The next request is taken as soon as the result sits in the output register. The
// modulus register (byte address 0, reset value 221) must only be written while the
// block is idle.
module modular_exponentiation_top #(
  parameter int OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mexp_pkg::field_t  in_base,
  input  mexp_pkg::field_t  in_exponent,
  output logic              out_valid,
  input  logic              out_stall,
  output mexp_pkg::field_t  out_power_residue,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  mexp_pkg::addr_t   paddr,
  input  mexp_pkg::data_t   pwdata,
  output mexp_pkg::data_t   prdata,
  output logic              pready
);

  mexp_pkg::field_t     modulus_r;
  logic                 reg_hit;
  logic                 wr_en;
  mexp_pkg::ctrl_cmd_t  cmd;
  mexp_pkg::dp_status_t status;

  // Register decode on the word index of the address.
  assign reg_hit = (paddr[mexp_pkg::ADDR_W-1:2] == mexp_pkg::REG_MODULUS);
  assign wr_en   = psel && penable && pwrite && pready && reg_hit;
  assign pready  = 1'b1;

  // Modulus register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= mexp_pkg::MODULUS_RESET;
    end else if (wr_en) begin
      modulus_r <= pwdata[mexp_pkg::FIELD_W-1:0];
    end
  end

  // Read data: the modulus, zero elsewhere.
  assign prdata = reg_hit ? mexp_pkg::data_t'(modulus_r) : '0;

  mexp_ctrl #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  mexp_datapath #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .modulus          (modulus_r),
    .in_base          (in_base),
    .in_exponent      (in_exponent),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_power_residue(out_power_residue)
  );

endmodule

>>> hw/rtl/mexp_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the modular exponentiation block, bound to the top level.
// Uses mexp_pkg for port types.
module mexp_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input mexp_pkg::field_t out_power_residue,
  input logic             psel,
  input logic             penable,
  input logic             pwrite,
  input mexp_pkg::addr_t  paddr,
  input mexp_pkg::data_t  pwdata,
  input mexp_pkg::data_t  prdata,
  input logic             pready
);

  // A held result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_power_residue))
    else $error("result changed or dropped while stalled");

  // One request at a time: after an acceptance the input side stalls.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request accepted while one is in progress");

  // A result never appears in the cycle right after an acceptance.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // A write to the modulus reads back on the next cycle.
  a_modulus_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && pready && paddr[2] == 1'b0) ##1 (paddr[2] == 1'b0)
    |-> prdata == {16'h0000, $past(pwdata[15:0])})
    else $error("modulus read-back mismatch");

endmodule

bind modular_exponentiation_top mexp_checker u_mexp_checker (.*);
